[rtl/qat_pkg.sv]
// types, constants and register indexes for the quote aware tokenizer
// no dependencies; imported by every module in rtl
package qat_pkg;

    localparam int MAX_DELIMITERS  = 4;
    localparam int MAX_QUOTE_PAIRS = 4;
    // a packed register holds four bytes, so never more than four slots
    localparam int DELIM_SLOTS = (MAX_DELIMITERS < 4) ? MAX_DELIMITERS : 4;
    localparam int QUOTE_SLOTS = (MAX_QUOTE_PAIRS < 4) ? MAX_QUOTE_PAIRS : 4;

    localparam int TOKEN_W     = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] ESCAPE_BYTE = 8'h5C;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_DELIM_BYTES = 3'd0;
    localparam logic [2:0] REG_DELIM_COUNT = 3'd1;
    localparam logic [2:0] REG_QOPEN_BYTES = 3'd2;
    localparam logic [2:0] REG_QCLOS_BYTES = 3'd3;
    localparam logic [2:0] REG_QPAIR_COUNT = 3'd4;

    localparam logic [31:0] RST_DELIM_BYTES = 32'd32;
    localparam logic [2:0]  RST_DELIM_COUNT = 3'd1;
    localparam logic [31:0] RST_QOPEN_BYTES = 32'd34;
    localparam logic [31:0] RST_QCLOS_BYTES = 32'd34;
    localparam logic [2:0]  RST_QPAIR_COUNT = 3'd1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               out_kind;
        logic [TOKEN_W-1:0] token_number;
        logic               run_last;
    } out_beat_t;

    // one classified byte: a kept byte, an end marker, or both
    typedef struct packed {
        logic               has_byte;
        logic               has_end;
        logic [7:0]         byte_val;
        logic [TOKEN_W-1:0] token_number;
    } tok_op_t;

endpackage

[rtl/qat_front.sv]
// front end: configuration registers, tokenizer state and byte classification
// depends on qat_pkg; feeds classified operations to qat_queue
module qat_front
    import qat_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,
    input  logic        q_full,
    output logic        op_push,
    output tok_op_t     op_data
);

    logic [31:0]        delim_bytes_reg;
    logic [2:0]         delim_count_reg;
    logic [31:0]        qopen_bytes_reg;
    logic [31:0]        qclos_bytes_reg;
    logic [2:0]         qpair_count_reg;

    logic               in_token_reg, in_token_next;
    logic [2:0]         open_quote_reg, open_quote_next;
    logic               esc_reg, esc_next;
    logic [TOKEN_W-1:0] token_count_reg, token_count_next;

    logic [2:0]         delim_used, qpair_used;
    logic               delim_hit;
    logic [2:0]         open_hit;
    logic [2:0]         oq_m1;
    logic [7:0]         close_byte;
    logic               keep, end_tok, accept;
    logic [7:0]         b;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.in_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_bytes_reg <= RST_DELIM_BYTES;
            delim_count_reg <= RST_DELIM_COUNT;
            qopen_bytes_reg <= RST_QOPEN_BYTES;
            qclos_bytes_reg <= RST_QCLOS_BYTES;
            qpair_count_reg <= RST_QPAIR_COUNT;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DELIM_BYTES: delim_bytes_reg <= cfg_wdata;
                REG_DELIM_COUNT: delim_count_reg <= cfg_wdata[2:0];
                REG_QOPEN_BYTES: qopen_bytes_reg <= cfg_wdata;
                REG_QCLOS_BYTES: qclos_bytes_reg <= cfg_wdata;
                REG_QPAIR_COUNT: qpair_count_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        delim_used = (delim_count_reg > 3'(DELIM_SLOTS)) ? 3'(DELIM_SLOTS) : delim_count_reg;
        qpair_used = (qpair_count_reg > 3'(QUOTE_SLOTS)) ? 3'(QUOTE_SLOTS) : qpair_count_reg;
        delim_hit  = 1'b0;
        for (int k = 0; k < DELIM_SLOTS; k++) begin
            if (3'(k) < delim_used && delim_bytes_reg[8*k +: 8] == b) delim_hit = 1'b1;
        end
        // walk downward so the lowest matching pair wins
        open_hit = 3'd0;
        for (int k = QUOTE_SLOTS - 1; k >= 0; k--) begin
            if (3'(k) < qpair_used && qopen_bytes_reg[8*k +: 8] == b) open_hit = 3'(k + 1);
        end
        oq_m1      = open_quote_reg - 3'd1;
        close_byte = qclos_bytes_reg[8*oq_m1[1:0] +: 8];
    end

    always_comb begin
        keep             = 1'b0;
        end_tok          = 1'b0;
        esc_next         = esc_reg;
        open_quote_next  = open_quote_reg;
        in_token_next    = in_token_reg;
        token_count_next = token_count_reg;

        if (esc_reg) begin
            esc_next = 1'b0;
            keep     = 1'b1;
        end else if (b == ESCAPE_BYTE) begin
            // a trailing backslash is kept as is
            if (s_data.in_last) keep = 1'b1;
            else esc_next = 1'b1;
        end else if (open_quote_reg != 3'd0) begin
            if (b == close_byte) open_quote_next = 3'd0;
            else keep = 1'b1;
        end else if (delim_hit) begin
            if (in_token_reg) end_tok = 1'b1;
        end else if (open_hit != 3'd0) begin
            open_quote_next = open_hit;
            in_token_next   = 1'b1;
        end else begin
            keep = 1'b1;
        end

        if (end_tok) in_token_next = 1'b0;
        if (keep) in_token_next = 1'b1;

        if (s_data.in_last) begin
            if (in_token_next || open_quote_next != 3'd0) end_tok = 1'b1;
            in_token_next    = 1'b0;
            open_quote_next  = 3'd0;
            esc_next         = 1'b0;
            token_count_next = '0;
        end else if (end_tok && token_count_reg != {TOKEN_W{1'b1}}) begin
            token_count_next = token_count_reg + TOKEN_W'(1);
        end

        op_data.has_byte     = keep;
        op_data.has_end      = end_tok;
        op_data.byte_val     = b;
        op_data.token_number = token_count_reg;
        op_push              = accept && (keep || end_tok);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_token_reg    <= 1'b0;
            open_quote_reg  <= 3'd0;
            esc_reg         <= 1'b0;
            token_count_reg <= '0;
        end else if (accept) begin
            in_token_reg    <= in_token_next;
            open_quote_reg  <= open_quote_next;
            esc_reg         <= esc_next;
            token_count_reg <= token_count_next;
        end
    end

    // end of text returns all scan state to reset
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.in_last |=> !in_token_reg && !esc_reg
            && open_quote_reg == 3'd0 && token_count_reg == '0)
        else $error("state not cleared after last beat");

    // an open quote always belongs to a token
    a_quote_in_token: assert property (@(posedge aclk) disable iff (!aresetn)
        open_quote_reg != 3'd0 |-> in_token_reg)
        else $error("quote open outside a token");

    a_quote_range: assert property (@(posedge aclk) disable iff (!aresetn)
        open_quote_reg <= 3'(QUOTE_SLOTS))
        else $error("open quote index out of range");

endmodule

[rtl/qat_queue.sv]
// small register queue of classified operations between front and back
// depends on qat_pkg
module qat_queue
    import qat_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  tok_op_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output tok_op_t head
);

    tok_op_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + QUEUE_CNT_W'(1);
        else if (pop && !push) count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            if (pop) rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH) && !(push && full))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue pop while empty");

endmodule

[rtl/qat_back.sv]
// back end: expands each operation into result beats in an output register
// depends on qat_pkg; drains qat_queue
module qat_back
    import qat_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_not_empty,
    input  tok_op_t   q_head,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic               out_valid_reg, out_valid_next;
    out_beat_t          out_data_reg, out_data_next;
    logic               pend_end_reg, pend_end_next;
    logic [TOKEN_W-1:0] pend_num_reg, pend_num_next;
    logic               load;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;
    assign load    = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pend_end_next  = pend_end_reg;
        pend_num_next  = pend_num_reg;
        q_pop          = 1'b0;
        if (load) begin
            out_valid_next = 1'b0;
            if (pend_end_reg) begin
                // second beat of a byte plus end pair
                out_valid_next             = 1'b1;
                out_data_next.out_byte     = 8'd0;
                out_data_next.out_kind     = KIND_END;
                out_data_next.token_number = pend_num_reg;
                out_data_next.run_last     = 1'b1;
                pend_end_next              = 1'b0;
            end else if (q_not_empty) begin
                q_pop                      = 1'b1;
                out_valid_next             = 1'b1;
                out_data_next.token_number = q_head.token_number;
                if (q_head.has_byte) begin
                    out_data_next.out_byte = q_head.byte_val;
                    out_data_next.out_kind = KIND_BYTE;
                    out_data_next.run_last = !q_head.has_end;
                    pend_end_next          = q_head.has_end;
                    pend_num_next          = q_head.token_number;
                end else begin
                    out_data_next.out_byte = 8'd0;
                    out_data_next.out_kind = KIND_END;
                    out_data_next.run_last = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        pend_num_reg <= pend_num_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pend_end_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            pend_end_reg  <= pend_end_next;
        end
    end

    // a pending end marker always sits behind a byte beat of the same token
    a_pend_behind_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_end_reg |-> out_valid_reg && out_data_reg.out_kind == KIND_BYTE
            && !out_data_reg.run_last && out_data_reg.token_number == pend_num_reg)
        else $error("pending end marker without its byte beat");

endmodule

[rtl/quote_aware_tokenizer.sv]
// top level of the quote aware tokenizer: front, operation queue, back
// depends on qat_pkg, qat_front, qat_queue, qat_back
//
//   port group   dir   handshake          payload
//   s_*          in    s_valid/s_ready    in_beat_t  (in_byte, in_last)
//   m_*          out   m_valid/m_ready    out_beat_t (out_byte, out_kind,
//                                                     token_number, run_last)
//   cfg_*        in    cfg_we             cfg_index, cfg_wdata
//
// one input beat per cycle while the four entry operation queue has room
// each beat yields zero, one or two result beats; the back end sends one per
// cycle while m_ready allows, so a byte that also closes a token gives a byte
// beat then an end beat; results go through a queue slot and output register
// reset is synchronous, active low, and restores the default configuration
// output stalls back up through the queue to s_ready
module quote_aware_tokenizer
    import qat_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data
);

    logic    q_full, q_push, q_pop, q_not_empty;
    tok_op_t q_in, q_head;

    qat_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .op_push   (q_push),
        .op_data   (q_in)
    );

    qat_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    qat_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

[verif/qat_checker.sv]
`timescale 1ns / 1ps
// qat_checker: watches the tokenizer's config port and both beat channels,
// predicts each result beat and compares it field by field; needs qat_pkg
module qat_checker
    import qat_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_beat_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_beat_t   m_data,
    output int          mismatch_count,
    output int          beats_due
);

    logic [31:0]        delim_word;
    logic [2:0]         delim_used;
    logic [31:0]        open_word;
    logic [31:0]        close_word;
    logic [2:0]         pair_used;

    logic               in_tok;
    logic [2:0]         open_q;
    logic               esc_pend;
    logic [TOKEN_W-1:0] tok_cnt;

    out_beat_t          token_beats[$];
    out_beat_t          want;

    function automatic int clip_count(logic [2:0] cnt, int limit);
        int n;
        n = cnt;
        if (n > limit) n = limit;
        if (n > 4) n = 4;
        return n;
    endfunction

    function automatic logic is_delim(logic [7:0] b);
        for (int k = 0; k < clip_count(delim_used, MAX_DELIMITERS); k++)
            if (delim_word[8*k +: 8] == b) return 1'b1;
        return 1'b0;
    endfunction

    // lowest pair wins; 0 means no opening byte matched
    function automatic logic [2:0] opener_of(logic [7:0] b);
        for (int k = 0; k < clip_count(pair_used, MAX_QUOTE_PAIRS); k++)
            if (open_word[8*k +: 8] == b) return 3'(k + 1);
        return 3'd0;
    endfunction

    task automatic emit(input logic [7:0] b, input logic kind);
        out_beat_t nb;
        nb.out_byte     = b;
        nb.out_kind     = kind;
        nb.token_number = tok_cnt;
        nb.run_last     = 1'b0;
        token_beats.push_back(nb);
    endtask

    task automatic close_token();
        emit(8'h00, KIND_END);
        if (tok_cnt != '1) tok_cnt++;
        in_tok = 1'b0;
    endtask

    task automatic tokenize_beat(input in_beat_t beat);
        logic       keep;
        logic [2:0] hit;
        int         first;
        keep  = 1'b0;
        first = token_beats.size();
        if (esc_pend) begin
            esc_pend = 1'b0;
            keep     = 1'b1;
        end else if (beat.in_byte == ESCAPE_BYTE) begin
            // a backslash on the final byte has nothing to escape
            if (beat.in_last) keep = 1'b1;
            else esc_pend = 1'b1;
        end else if (open_q != 3'd0) begin
            if (beat.in_byte == close_word[8*(open_q-1) +: 8]) open_q = 3'd0;
            else keep = 1'b1;
        end else if (is_delim(beat.in_byte)) begin
            if (in_tok) close_token();
        end else begin
            hit = opener_of(beat.in_byte);
            if (hit != 3'd0) begin
                open_q = hit;
                in_tok = 1'b1;
            end else begin
                keep = 1'b1;
            end
        end

        if (keep) begin
            in_tok = 1'b1;
            emit(beat.in_byte, KIND_BYTE);
        end

        if (beat.in_last) begin
            if (in_tok || open_q != 3'd0) close_token();
            in_tok   = 1'b0;
            open_q   = 3'd0;
            esc_pend = 1'b0;
            tok_cnt  = '0;
        end

        if (token_beats.size() > first)
            token_beats[token_beats.size()-1].run_last = 1'b1;
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            delim_word = RST_DELIM_BYTES;
            delim_used = RST_DELIM_COUNT;
            open_word  = RST_QOPEN_BYTES;
            close_word = RST_QCLOS_BYTES;
            pair_used  = RST_QPAIR_COUNT;
            in_tok     = 1'b0;
            open_q     = 3'd0;
            esc_pend   = 1'b0;
            tok_cnt    = '0;
            token_beats.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_DELIM_BYTES: delim_word = cfg_wdata;
                    REG_DELIM_COUNT: delim_used = cfg_wdata[2:0];
                    REG_QOPEN_BYTES: open_word  = cfg_wdata;
                    REG_QCLOS_BYTES: close_word = cfg_wdata;
                    REG_QPAIR_COUNT: pair_used  = cfg_wdata[2:0];
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (token_beats.size() == 0) begin
                    $error("result beat with nothing expected: byte %0h kind %0d tok %0d",
                           m_data.out_byte, m_data.out_kind, m_data.token_number);
                    mismatch_count++;
                end else begin
                    want = token_beats.pop_front();
                    check_field("out_byte", want.out_byte, m_data.out_byte);
                    check_field("out_kind", want.out_kind, m_data.out_kind);
                    check_field("token_number", want.token_number, m_data.token_number);
                    check_field("run_last", want.run_last, m_data.run_last);
                end
            end

            if (s_valid && s_ready) tokenize_beat(s_data);
        end
        beats_due = token_beats.size();
    end

endmodule

[verif/quote_aware_tokenizer_tb.sv]
`timescale 1ns / 1ps
// quote_aware_tokenizer_tb: clock, reset, config writes and byte stimulus
// for the tokenizer; results are judged by qat_checker; needs qat_pkg
module quote_aware_tokenizer_tb;
    import qat_pkg::*;

    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_BEATS   = 140;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 200;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    in_beat_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_beat_t   m_data;

    int          mismatch_count;
    int          beats_due;
    int          idle_pct = 28;
    bit          hold_request = 1'b0;

    // what was last written, so stimulus can aim at the configured bytes
    logic [31:0] cur_delim = RST_DELIM_BYTES;
    logic [31:0] cur_open  = RST_QOPEN_BYTES;
    logic [31:0] cur_close = RST_QCLOS_BYTES;

    quote_aware_tokenizer dut (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
    );

    qat_checker u_token_check (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .mismatch_count, .beats_due
    );

    always #4 aclk = ~aclk;

    initial begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_done) begin
                m_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic l);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_data.in_byte  <= b;
        s_data.in_last  <= l;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic apply_config(input logic [31:0] dw, input logic [2:0] dc,
                                input logic [31:0] ow, input logic [31:0] cw,
                                input logic [2:0] pc);
        // upper bits of the count writes are don't-care
        write_reg(REG_DELIM_BYTES, dw);
        write_reg(REG_DELIM_COUNT, {29'($urandom()), dc});
        write_reg(REG_QOPEN_BYTES, ow);
        write_reg(REG_QCLOS_BYTES, cw);
        write_reg(REG_QPAIR_COUNT, {29'($urandom()), pc});
        cfg_we    <= 1'b0;
        cur_delim = dw;
        cur_open  = ow;
        cur_close = cw;
    endtask

    // wait until every predicted beat is out and the block has gone quiet
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (beats_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        for (int k = 0; k < 4; k++)
            w[8*k +: 8] = $urandom_range(1) ? 8'($urandom_range(33, 126))
                                            : 8'($urandom_range(255));
        return w;
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        int k;
        r = $urandom_range(99);
        k = $urandom_range(3);
        if (r < 15) return cur_delim[8*k +: 8];
        if (r < 25) return cur_open[8*k +: 8];
        if (r < 35) return cur_close[8*k +: 8];
        if (r < 40) return ESCAPE_BYTE;
        if (r < 85) return 8'($urandom_range(97, 122));
        return 8'($urandom_range(255));
    endfunction

    initial begin
        int sent;
        int len;
        bit hold_sent;

        hold_sent  = 1'b0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_DELIM_BYTES;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        repeat (3) @(posedge aclk);
        aresetn   <= 1'b1;
        @(posedge aclk);

        // default setup: space delimits, double quote pairs with itself
        idle_pct = 28;
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(" ", 1'b0);
        send_beat(" ", 1'b0);          // repeated delimiter, nothing out
        send_beat("\"", 1'b0);
        send_beat(" ", 1'b0);          // delimiter kept inside quotes
        send_beat(ESCAPE_BYTE, 1'b0);
        send_beat("\"", 1'b0);         // escaped quote is literal
        send_beat("\"", 1'b0);
        send_beat(" ", 1'b0);
        send_beat("\"", 1'b0);
        send_beat("\"", 1'b0);         // empty quoted pair is a token
        send_beat(" ", 1'b0);
        send_beat(ESCAPE_BYTE, 1'b0);
        send_beat(" ", 1'b0);          // escaped delimiter starts a token
        send_beat("x", 1'b1);          // byte and end marker together
        send_beat(ESCAPE_BYTE, 1'b1);  // trailing backslash kept
        send_beat("\"", 1'b1);         // quote still open at end of text
        send_beat(" ", 1'b1);          // no token, no result

        // overlapping bytes: ';' is delimiter and opener, '[' opens two pairs,
        // counts above the limit
        drain();
        apply_config(32'h2C3B2009, 3'd7, 32'h3B5B285B, 32'h3B3E295D, 3'd5);
        send_beat("]", 1'b0);          // stray close is plain
        send_beat("[", 1'b0);
        send_beat(">", 1'b0);          // close of the higher pair only
        send_beat("]", 1'b0);
        send_beat(";", 1'b0);
        send_beat("(", 1'b0);
        send_beat(",", 1'b0);
        send_beat(")", 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            case (p)
                0: apply_config(32'h093B2C20, 3'd4, 32'h5B282722, 32'h5D292722, 3'd4);
                1: apply_config(rand_word(), 3'd0, rand_word(), rand_word(), 3'd0);
                2: apply_config(32'hFFFFFFFF, 3'd7, 32'hFEFEFEFE, 32'hFFFFFFFF, 3'd7);
                3: apply_config(32'h00000000, 3'd4, 32'h00000000, 32'h00000000, 3'd4);
                default: apply_config(rand_word(), 3'($urandom_range(7)), rand_word(),
                                      rand_word(), 3'($urandom_range(7)));
            endcase
            idle_pct = (p == 0) ? 0 : 28;
            sent = 0;
            while (sent < PHASE_BEATS) begin
                if (p == 0 && sent >= 40 && !hold_sent) begin
                    hold_request = 1'b1;
                    hold_sent    = 1'b1;
                end
                len = $urandom_range(1, 24);
                for (int i = 0; i < len; i++)
                    send_beat(pick_byte(), i == len - 1);
                sent += len;
            end
        end

        drain();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
